### rtl/core/deqs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deqs_pkg
// Shared types and codes for the double-ended queue with search.
// ----------------------------------------------------------------------------
package deqs_pkg;

  localparam int OPCODE_W = 3;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int OCC_W    = 5;

  localparam logic [OPCODE_W-1:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_POP_FRONT  = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_POP_BACK   = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_SEARCH     = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [OPCODE_W-1:0]       opcode;
    logic signed [VALUE_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                found;
    logic [OCC_W-1:0]    occupancy;
  } rsp_t;

  typedef struct packed {
    logic accept;
    logic step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic start_search;
    logic done;
    logic hit;
  } sts_t;

endpackage

### rtl/core/deqs_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deqs_ctrl
// Sequencer: request handshake, search walk control and result valid.
// ----------------------------------------------------------------------------
module deqs_ctrl
  import deqs_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  output logic rsp_valid,
  input  logic rsp_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE   = 2'b01,
    S_SEARCH = 2'b10
  } state_t;

  state_t state, state_next;
  logic   rsp_valid_next;

  assign req_ready = (state == S_IDLE) && (!rsp_valid || rsp_ready);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        cmd.accept = req_valid && req_ready;
        if (cmd.accept && sts.start_search) begin
          state_next = S_SEARCH;
        end
      end
      S_SEARCH: begin
        cmd.step   = !sts.done;
        cmd.finish = sts.done;
        if (sts.done) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    rsp_valid_next = rsp_valid;
    if (rsp_valid && rsp_ready) begin
      rsp_valid_next = 1'b0;
    end
    if ((cmd.accept && !sts.start_search) || cmd.finish) begin
      rsp_valid_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rsp_valid <= rsp_valid_next;
    end
  end

endmodule

### rtl/core/deqs_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deqs_dp
// Ring store, front/count registers, search walker and result register.
// ----------------------------------------------------------------------------
module deqs_dp
  import deqs_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic clk,
  input  logic rst,
  input  req_t req,
  input  cmd_t cmd,
  output sts_t sts,
  output rsp_t rsp
);

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = IW + 1;

  logic [VALUE_W-1:0] mem [DEPTH];

  logic [IW-1:0] front, front_next;
  logic [CW-1:0] count, count_next;

  logic [IW-1:0]       rd_ptr;
  logic [CW-1:0]       rd_left;
  logic [VALUE_W-1:0]  rd_data;
  logic [VALUE_W-1:0]  key;
  logic                cmp_vld;
  logic                cmp_last;

  logic                wr_en;
  logic [IW-1:0]       wr_addr;
  logic [SW-1:0]       back_sum;
  logic [IW-1:0]       back_pos;
  logic [IW-1:0]       front_inc;
  logic [IW-1:0]       front_dec;
  logic [IW-1:0]       rd_ptr_inc;
  logic [STATUS_W-1:0] imm_status;
  logic                full;
  logic                empty;

  assign full  = (count >= CW'(DEPTH));
  assign empty = (count == '0);

  assign back_sum  = SW'(front) + SW'(count);
  assign back_pos  = (back_sum >= SW'(DEPTH)) ? IW'(back_sum - SW'(DEPTH)) : IW'(back_sum);
  assign front_inc = (front == IW'(DEPTH - 1)) ? '0 : front + IW'(1);
  assign front_dec = (front == '0) ? IW'(DEPTH - 1) : front - IW'(1);
  assign rd_ptr_inc = (rd_ptr == IW'(DEPTH - 1)) ? '0 : rd_ptr + IW'(1);

  always_comb begin
    front_next = front;
    count_next = count;
    wr_en      = 1'b0;
    wr_addr    = back_pos;
    imm_status = ST_OK;
    case (req.opcode)
      OP_PUSH_FRONT: begin
        if (full) begin
          imm_status = ST_FULL;
        end else begin
          front_next = front_dec;
          wr_addr    = front_dec;
          wr_en      = 1'b1;
          count_next = count + CW'(1);
        end
      end
      OP_PUSH_BACK: begin
        if (full) begin
          imm_status = ST_FULL;
        end else begin
          wr_en      = 1'b1;
          count_next = count + CW'(1);
        end
      end
      OP_POP_FRONT: begin
        if (empty) begin
          imm_status = ST_EMPTY;
        end else begin
          front_next = front_inc;
          count_next = count - CW'(1);
        end
      end
      OP_POP_BACK: begin
        if (empty) begin
          imm_status = ST_EMPTY;
        end else begin
          count_next = count - CW'(1);
        end
      end
      OP_SEARCH: begin
        if (empty) begin
          imm_status = ST_EMPTY;
        end
      end
      default: begin
        imm_status = ST_OK;
      end
    endcase
  end

  assign sts.start_search = (req.opcode == OP_SEARCH) && !empty;
  assign sts.hit          = cmp_vld && (rd_data == key);
  assign sts.done         = cmp_vld && ((rd_data == key) || cmp_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      front <= '0;
      count <= '0;
    end else if (cmd.accept) begin
      front <= front_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && wr_en) begin
      mem[wr_addr] <= req.value;
    end
    if (cmd.step && (rd_left != '0)) begin
      rd_data <= mem[rd_ptr];
    end
  end

  // search walker: one read issued and one compare per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      cmp_vld <= 1'b0;
    end else if (cmd.accept) begin
      cmp_vld <= 1'b0;
    end else if (cmd.step) begin
      cmp_vld <= (rd_left != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      rd_ptr  <= front;
      rd_left <= count;
      key     <= req.value;
    end else if (cmd.step && (rd_left != '0)) begin
      rd_ptr   <= rd_ptr_inc;
      rd_left  <= rd_left - CW'(1);
      cmp_last <= (rd_left == CW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      rsp.status    <= imm_status;
      rsp.found     <= 1'b0;
      rsp.occupancy <= OCC_W'(count_next);
    end else if (cmd.finish) begin
      rsp.status    <= ST_OK;
      rsp.found     <= sts.hit;
      rsp.occupancy <= OCC_W'(count);
    end
  end

endmodule

### rtl/core/double_ended_queue_with_search.sv
// Pushes, pops and searches of an empty queue: result registered in the cycle after the request is taken.
// Search of n held entries: one ring-store read port walks one entry a cycle until a match or the last entry.
// One request in flight at a time; the next is taken as the result is taken.
// Reset clears front index, count and control; store contents stay undefined until written.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_ended_queue_with_search
// Bounded deque of signed words in a ring store, with equality search.
// ----------------------------------------------------------------------------
module double_ended_queue_with_search
  import deqs_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  cmd_t cmd;
  sts_t sts;

  deqs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  deqs_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk (clk),
    .rst (rst),
    .req (req),
    .cmd (cmd),
    .sts (sts),
    .rsp (rsp)
  );

endmodule
